// ===== hw/rtl/lz77wd_pkg.sv =====
// Shared types and constants for the LZ77 window decoder.
// Used by lz77wd_ctrl, lz77wd_dp and lz77_window_decoder_top.
package lz77wd_pkg;

  localparam int HISTORY_DEPTH = 4096;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

  localparam logic [4:0] LEN_BIAS   = 5'd3;
  localparam logic [3:0] FLAG_COUNT = 4'd8;
  localparam logic [1:0] HDR_LAST   = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_REF_LO
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_RD,
    ST_CP
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic emit_lit;
    logic rd;
    logic emit_cp;
  } dp_cmd_t;

  typedef struct packed {
    logic lit_tok;
    logic ref_tok;
    logic copy_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/lz77wd_ctrl.sv =====
// Controller state machine for the LZ77 window decoder.
// Depends on lz77wd_pkg; drives commands into lz77wd_dp.
module lz77wd_ctrl import lz77wd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (sts.lit_tok) begin
            state_nxt = ST_LIT;
          end else if (sts.ref_tok) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_LIT: begin
        if (sts.out_free) begin
          cmd.emit_lit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CP;
      end
      ST_CP: begin
        if (sts.out_free) begin
          cmd.emit_cp = 1'b1;
          state_nxt   = sts.copy_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/lz77wd_dp.sv =====
// Datapath for the LZ77 window decoder: header/flag parsing, history memory,
// copy pointers and the output register. Depends on lz77wd_pkg.
module lz77wd_dp import lz77wd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_end
);

  localparam logic [HIST_AW-1:0] LAST_IDX = HIST_AW'(HISTORY_DEPTH - 1);
  localparam logic [HIST_AW:0]   DEPTH_W  = (HIST_AW + 1)'(HISTORY_DEPTH);

  // parse state
  phase_t             phase_r, phase_nxt;
  logic [1:0]         hcnt_r, hcnt_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [3:0]         flags_left_r, flags_left_nxt;
  logic signed [24:0] rem_r, rem_nxt;
  logic [4:0]         pend_len_r, pend_len_nxt;
  logic [3:0]         dhi_r, dhi_nxt;
  logic               end_r, end_nxt;

  // copy and history state
  logic [HIST_AW-1:0] wp_r, rd_ptr_r, rd_ptr_nxt;
  logic               full_r;
  logic [4:0]         len_cnt_r;
  logic [7:0]         lit_r;
  logic [7:0]         rd_data_r;
  logic               rd_zero_r;
  logic [7:0]         hist_mem [HISTORY_DEPTH];

  // output register
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic               out_end_r;

  logic               emit;
  logic [7:0]         emit_byte;
  logic [12:0]        back_dist;
  logic [HIST_AW:0]   rd_diff;
  logic signed [24:0] rem_tok;
  logic               tok_done;

  assign sts.lit_tok   = (phase_r == PH_TOKEN) && !flags_r[7];
  assign sts.ref_tok   = (phase_r == PH_REF_LO);
  assign sts.copy_last = (len_cnt_r == 5'd1);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign emit      = cmd.emit_lit || cmd.emit_cp;
  assign emit_byte = cmd.emit_lit ? lit_r : (rd_zero_r ? 8'd0 : rd_data_r);

  // start of copy: distance back from the write pointer, wrapped into the window
  assign back_dist  = {1'b0, dhi_r, in_byte} + 13'd1;
  assign rd_diff    = {1'b0, wp_r} - (HIST_AW + 1)'(back_dist);
  assign rd_ptr_nxt = rd_diff[HIST_AW] ? HIST_AW'(rd_diff + DEPTH_W) : rd_diff[HIST_AW-1:0];

  always_comb begin
    phase_nxt      = phase_r;
    hcnt_nxt       = hcnt_r;
    flags_nxt      = flags_r;
    flags_left_nxt = flags_left_r;
    rem_nxt        = rem_r;
    pend_len_nxt   = pend_len_r;
    dhi_nxt        = dhi_r;
    end_nxt        = end_r;
    rem_tok        = rem_r - 25'sd1;
    tok_done       = 1'b0;
    if (cmd.accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          unique case (hcnt_r)
            2'd0: rem_nxt = '0;
            2'd1: rem_nxt[7:0] = in_byte;
            2'd2: rem_nxt[15:8] = in_byte;
            default: rem_nxt[23:16] = in_byte;
          endcase
          if (hcnt_r == HDR_LAST) begin
            hcnt_nxt  = 2'd0;
            phase_nxt = (rem_nxt != '0) ? PH_FLAG : PH_HEADER;
          end else begin
            hcnt_nxt = hcnt_r + 2'd1;
          end
        end
        PH_FLAG: begin
          flags_nxt      = in_byte;
          flags_left_nxt = FLAG_COUNT;
          phase_nxt      = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (!flags_r[7]) begin
            rem_tok  = rem_r - 25'sd1;
            tok_done = 1'b1;
          end else begin
            pend_len_nxt = LEN_BIAS + {1'b0, in_byte[7:4]};
            dhi_nxt      = in_byte[3:0];
            phase_nxt    = PH_REF_LO;
          end
        end
        default: begin
          rem_tok  = rem_r - $signed({20'd0, pend_len_r});
          tok_done = 1'b1;
        end
      endcase
    end
    if (tok_done) begin
      rem_nxt        = rem_tok;
      flags_nxt      = {flags_r[6:0], 1'b0};
      flags_left_nxt = (flags_left_r != 4'd0) ? flags_left_r - 4'd1 : 4'd0;
      end_nxt        = rem_tok[24] || (rem_tok == '0);
      if (end_nxt) begin
        phase_nxt      = PH_HEADER;
        hcnt_nxt       = 2'd0;
        flags_left_nxt = 4'd0;
        flags_nxt      = 8'd0;
      end else begin
        phase_nxt = (flags_left_nxt != 4'd0) ? PH_TOKEN : PH_FLAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hcnt_r       <= 2'd0;
      flags_r      <= 8'd0;
      flags_left_r <= 4'd0;
      rem_r        <= '0;
      pend_len_r   <= 5'd0;
      dhi_r        <= 4'd0;
      end_r        <= 1'b0;
      wp_r         <= '0;
      full_r       <= 1'b0;
      len_cnt_r    <= 5'd0;
      rd_ptr_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hcnt_r       <= hcnt_nxt;
      flags_r      <= flags_nxt;
      flags_left_r <= flags_left_nxt;
      rem_r        <= rem_nxt;
      pend_len_r   <= pend_len_nxt;
      dhi_r        <= dhi_nxt;
      end_r        <= end_nxt;
      if (cmd.accept && sts.ref_tok) begin
        len_cnt_r <= pend_len_r;
        rd_ptr_r  <= rd_ptr_nxt;
      end
      if (emit) begin
        wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
        if (wp_r == LAST_IDX) begin
          full_r <= 1'b1;
        end
      end
      if (cmd.emit_cp) begin
        len_cnt_r <= len_cnt_r - 5'd1;
        rd_ptr_r  <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lit_r <= in_byte;
    end
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.emit_lit || sts.copy_last;
      out_end_r  <= end_r && (cmd.emit_lit || sts.copy_last);
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (emit) begin
      hist_mem[wp_r] <= emit_byte;
    end
  end

  // entries at or past the write pointer before the first wrap read as zero
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= hist_mem[rd_ptr_r];
      rd_zero_r <= !full_r && (rd_ptr_r >= wp_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_end   = out_end_r;

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("emit into an occupied output register");

  a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_cp |-> (len_cnt_r != 5'd0))
    else $error("copy beat with no bytes left");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted byte not presented");

  a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> out_last_r)
    else $error("stream end on a byte that is not the last of its run");
`endif

endmodule

// ===== hw/rtl/lz77_window_decoder_top.sv =====
// LZ77 window decoder: compressed byte stream in, decompressed bytes out.
// Channels: in_* takes one compressed byte per transfer (4-byte header,
// then flag bytes and tokens). out_* returns decompressed bytes; out_tlast
// marks the last byte caused by one input byte, out_tuser the final byte of
// a stream. Header, flag and first reference bytes produce no output.
// A non-emitting byte is accepted and the block stays ready for the next; a literal
// is accepted, then loaded into the output register. A back reference of
// length L is accepted with its second byte, then each of its L copied bytes
// needs a read step of the 4096-byte history, then a write/emit step, so
// overlapping copies always see the byte just written.
// First output appears in the cycle after the emit step, from a registered
// output stage; the block keeps parsing while a byte waits there.
// Receiver stall: a held output byte blocks the next emit step only;
// in_tready stays low until the current token has been emitted in full.
// Reset (rst_n low, synchronous) returns the parser to expecting a header
// and the history to all zeros, tracked by the write pointer so no clearing
// pass is needed; the block accepts input as soon as reset is released.
// Depends on lz77wd_pkg, lz77wd_ctrl and lz77wd_dp.
module lz77_window_decoder_top import lz77wd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // [0] stream_end
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lz77wd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lz77wd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_end   (out_tuser)
  );

endmodule

// ===== test/lz77_window_decoder_top_test.sv =====
// Testbench for lz77_window_decoder_top: drives compressed byte streams and checks each
// decompressed byte and its flags against directed rows or a built-in LZ77 decoder model.
// Depends on lz77wd_pkg and lz77_window_decoder_top.
`timescale 1ns / 100ps

module lz77_window_decoder_top_test;
  import lz77wd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       stream_end;
  } out_byte_t;

  // One directed transfer; dout/last/stream_end only count when fixed and has_out are set.
  typedef struct packed {
    logic [7:0] din;
    logic       fixed;
    logic       has_out;
    logic [7:0] dout;
    logic       last;
    logic       stream_end;
  } dir_row_t;

  localparam int DIR_ROWS      = 26;
  localparam int RAND_ITEMS    = 285;
  localparam int CALM_FROM     = 235;
  localparam int TAIL_FROM     = 255;
  localparam int DRAIN_LATENCY = 40;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  bit calm     = 1'b0;
  bit big_tail = 1'b0;
  int mismatches = 0;

  out_byte_t decoded_bytes [$];

  // decoder model state
  logic [7:0]         hist [HISTORY_DEPTH];
  logic [HIST_AW-1:0] wr_ptr;
  logic signed [24:0] rem_size;
  phase_t             phase;
  logic [1:0]         hdr_cnt;
  logic [7:0]         flag_bits;
  logic [3:0]         flags_left;
  logic [4:0]         ref_len;
  logic [3:0]         ref_dist_hi;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // zero-size header: the stream ends with no output
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // size 5: literal, then a longest reference at the farthest distance that
    // reads the cleared history, runs past the size and drops the leftover flags
    '{8'h10, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h05, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h40, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // size 1: one literal ends the stream
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hA5, 1'b1, 1'b1, 8'hA5, 1'b1, 1'b1},
    // size 2: literal, then a distance-1 reference repeats it three times
    '{8'h7E, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h02, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h7F, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h5A, 1'b1, 1'b1, 8'h5A, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  lz77_window_decoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decode one compressed byte; queue the decompressed bytes it yields when keep is set.
  task automatic decode_byte(input logic [7:0] b, input bit keep);
    out_byte_t          run [18];
    int                 n;
    int                 k;
    bit                 tok_done;
    logic [12:0]        back_dist;
    logic [HIST_AW-1:0] idx;
    n = 0;
    tok_done = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (hdr_cnt == 2'd0) rem_size = '0;
        else rem_size = rem_size | (25'(b) << (8 * (hdr_cnt - 2'd1)));
        if (hdr_cnt == HDR_LAST) begin
          hdr_cnt = 2'd0;
          phase = (rem_size > 0) ? PH_FLAG : PH_HEADER;
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
      end
      PH_FLAG: begin
        flag_bits = b;
        flags_left = FLAG_COUNT;
        phase = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (!flag_bits[7]) begin
          hist[wr_ptr] = b;
          wr_ptr = wr_ptr + 1'b1;
          run[n] = '{b, 1'b0, 1'b0};
          n++;
          rem_size = rem_size - 25'sd1;
          tok_done = 1'b1;
        end else begin
          ref_len = LEN_BIAS + 5'(b[7:4]);
          ref_dist_hi = b[3:0];
          phase = PH_REF_LO;
        end
      end
      PH_REF_LO: begin
        back_dist = {1'b0, ref_dist_hi, b} + 13'd1;
        // copy one byte at a time so an overlapping copy sees what it just wrote
        for (k = 0; k < ref_len; k++) begin
          idx = wr_ptr - back_dist[HIST_AW-1:0];
          run[n] = '{hist[idx], 1'b0, 1'b0};
          hist[wr_ptr] = hist[idx];
          wr_ptr = wr_ptr + 1'b1;
          n++;
        end
        rem_size = rem_size - 25'(ref_len);
        tok_done = 1'b1;
      end
    endcase
    if (tok_done) begin
      flag_bits = flag_bits << 1;
      if (flags_left != 4'd0) flags_left = flags_left - 4'd1;
      if (!(rem_size > 0)) begin
        // stream done: drop any flags still pending
        phase = PH_HEADER;
        hdr_cnt = 2'd0;
        flags_left = 4'd0;
        flag_bits = 8'h00;
      end else begin
        phase = (flags_left != 4'd0) ? PH_TOKEN : PH_FLAG;
      end
    end
    if (n > 0) begin
      run[n-1].last = 1'b1;
      run[n-1].stream_end = (phase == PH_HEADER && hdr_cnt == 2'd0);
    end
    if (keep) begin
      for (k = 0; k < n; k++) decoded_bytes.push_back(run[k]);
    end
  endtask

  // Pick the next compressed byte so that streams stay short (until big_tail is set) and references mostly stay near.
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    case (phase)
      PH_HEADER: begin
        if (big_tail) begin
          v = 8'hFF;
        end else if (hdr_cnt == 2'd1) begin
          if ($urandom_range(0, 11) == 0) v = 8'h00;
          else if ($urandom_range(0, 9) != 0) v = 8'($urandom_range(1, 48));
        end else if (hdr_cnt != 2'd0) begin
          v = 8'h00;
        end
      end
      PH_TOKEN: begin
        if (flag_bits[7] && $urandom_range(0, 3) != 0) v[3:0] = 4'h0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin
    int         i;
    int         k;
    logic [7:0] b;
    for (k = 0; k < HISTORY_DEPTH; k++) hist[k] = 8'h00;
    wr_ptr = '0;
    rem_size = '0;
    phase = PH_HEADER;
    hdr_cnt = 2'd0;
    flag_bits = 8'h00;
    flags_left = 4'd0;
    ref_len = 5'd0;
    ref_dist_hi = 4'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      idle_burst();
      send_byte(dir_rows[i].din);
      decode_byte(dir_rows[i].din, !dir_rows[i].fixed);
      if (dir_rows[i].fixed && dir_rows[i].has_out)
        decoded_bytes.push_back('{dir_rows[i].dout, dir_rows[i].last, dir_rows[i].stream_end});
    end

    for (i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= CALM_FROM);
      if (i == 0 || i == RAND_ITEMS / 2) begin
        // hold off until every decompressed byte has come back
        in_tvalid <= 1'b0;
        while (decoded_bytes.size() != 0) @(posedge clk);
      end else begin
        idle_burst();
      end
      // finish on a maximum-size header whose stream never completes
      if (i >= TAIL_FROM && phase == PH_HEADER && hdr_cnt == 2'd0) big_tail = 1'b1;
      b = pick_byte();
      send_byte(b);
      decode_byte(b, 1'b1);
    end
    in_tvalid <= 1'b0;

    while (decoded_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_LATENCY) @(posedge clk);
    if (mismatches == 0 && decoded_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    wait (rst_n);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Sample at the edge, compare after the edge's queue updates have settled.
  always @(posedge clk) begin : out_check
    out_byte_t got;
    out_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tlast, out_tuser};
      @(negedge clk);
      if (decoded_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: byte %02h last %0b stream_end %0b",
                   got.data, got.last, got.stream_end);
      end else begin
        want = decoded_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     want.data, want.last, want.stream_end,
                     got.data, got.last, got.stream_end);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lz77wd_pkg.sv
hw/rtl/lz77wd_ctrl.sv
hw/rtl/lz77wd_dp.sv
hw/rtl/lz77_window_decoder_top.sv
test/lz77_window_decoder_top_test.sv
